// ===== hdl/string_literal_escape_encoder_core_macros.svh =====
// Assertion macros used by the escape encoder's serializer module.
`ifndef STRING_LITERAL_ESCAPE_ENCODER_CORE_MACROS_SVH
`define STRING_LITERAL_ESCAPE_ENCODER_CORE_MACROS_SVH

// Check on every clock edge, disabled while in reset.
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/sle_pkg.sv =====
// Types and constants of the string literal escape encoder.
`timescale 1ns / 1ps
package sle_pkg;

  localparam int unsigned MaxChars = 4;
  localparam int unsigned CntW     = 2;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTilde     = 8'h7E;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChN         = 8'h6E;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntW-1:0]          last_idx;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// ===== hdl/string_literal_escape_encoder_core.sv =====
// Top level of the string literal escape encoder.
// Usage:
//   Input stream: one raw byte per beat on s_axis_tdata, with s_axis_tuser set
//   on the first byte of a new chunk. Output stream: one escaped character per
//   beat on m_axis_tdata, m_axis_tlast marking the final character of a byte.
//   A byte yields one to four characters.
// Path: a byte accepted into the input register is encoded combinationally
//   and loaded into the result register once the serializer is free (input
//   register, then encode into the result register); its first character is
//   then offered from the result register.
// Throughput: one character per cycle on the output while m_axis_tready is
//   high, so the output port is the limit; a byte holds the result register
//   until its last character is taken. The next byte waits in the input register and
//   loads on the cycle the last character of the previous byte is taken.
// Reset: rst_ni clears both registers' valid flags and the digit guard
//   state; the first byte after reset is never guarded.
// Stall: while m_axis_tready is low the current character holds; the input
//   register fills and s_axis_tready drops until the result register frees.
`timescale 1ns / 1ps
module string_literal_escape_encoder_core
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] chunk_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // last_char
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       load;
  logic       in_take;
  result_t    result;

  assign s_axis_tready = !in_valid_q || load;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  sle_encode u_encode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .in_byte_i     (in_byte_q),
    .chunk_start_i (in_start_q),
    .result_o      (result)
  );

  sle_serialize u_serialize (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_q),
    .result_i      (result),
    .load_o        (load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hdl/sle_encode.sv =====
// Escape encoder: guard state and the character sequence for one byte.
`timescale 1ns / 1ps
module sle_encode
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [7:0] in_byte_i,
  input  logic       chunk_start_i,
  output result_t    result_o
);

  logic       guard_q, guard_d;
  logic       prev_digit_q, prev_digit_d;
  logic       guard_eff;
  logic       is_esc_pair, is_newline, is_numeric;
  logic [1:0] hund;
  logic [7:0] rem8;
  logic [6:0] rem7;
  logic [14:0] prod;
  logic [3:0] tens;
  logic [6:0] ones_full;
  logic [3:0] ones;
  logic [7:0] c_hund, c_tens, c_ones;

  assign guard_eff   = chunk_start_i ? prev_digit_q : guard_q;
  assign is_esc_pair = (in_byte_i == ChQuote) || (in_byte_i == ChBackslash);
  assign is_newline  = (in_byte_i == ChNewline);
  assign is_numeric  = (in_byte_i < ChSpace) || (in_byte_i > ChTilde) ||
                       (is_digit(in_byte_i) && guard_eff);

  assign hund = (in_byte_i >= 8'd200) ? 2'd2 : ((in_byte_i >= 8'd100) ? 2'd1 : 2'd0);
  assign rem8 = in_byte_i - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
  assign rem7 = rem8[6:0];
  assign prod = {8'b0, rem7} * 15'd205;
  assign tens = prod[14:11];
  assign ones_full = rem7 - ({3'b0, tens} * 7'd10);
  assign ones = ones_full[3:0];

  assign c_hund = ChZero + {6'b0, hund};
  assign c_tens = ChZero + {4'b0, tens};
  assign c_ones = ChZero + {4'b0, ones};

  always_comb begin
    result_o.chars    = '0;
    result_o.last_idx = '0;
    guard_d           = 1'b0;
    prev_digit_d      = 1'b0;
    if (is_esc_pair) begin
      result_o.chars[0] = ChBackslash;
      result_o.chars[1] = in_byte_i;
      result_o.last_idx = 2'd1;
    end else if (is_newline) begin
      result_o.chars[0] = ChBackslash;
      result_o.chars[1] = ChN;
      result_o.last_idx = 2'd1;
    end else if (is_numeric) begin
      result_o.chars[0] = ChBackslash;
      prev_digit_d      = 1'b1;
      guard_d           = (in_byte_i < 8'd100);
      if (in_byte_i >= 8'd100) begin
        result_o.chars[1] = c_hund;
        result_o.chars[2] = c_tens;
        result_o.chars[3] = c_ones;
        result_o.last_idx = 2'd3;
      end else if (in_byte_i >= 8'd10) begin
        result_o.chars[1] = c_tens;
        result_o.chars[2] = c_ones;
        result_o.last_idx = 2'd2;
      end else begin
        result_o.chars[1] = c_ones;
        result_o.last_idx = 2'd1;
      end
    end else begin
      result_o.chars[0] = in_byte_i;
      prev_digit_d      = is_digit(in_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q      <= 1'b0;
      prev_digit_q <= 1'b0;
    end else if (load_i) begin
      guard_q      <= guard_d;
      prev_digit_q <= prev_digit_d;
    end
  end

endmodule

// ===== hdl/sle_serialize.sv =====
// Result register and beat sequencer for the escaped characters.
`timescale 1ns / 1ps
module sle_serialize
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  result_t    result_i,
  output logic       load_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  `include "string_literal_escape_encoder_core_macros.svh"

  logic            busy_q, busy_d;
  result_t         res_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic            beat_done, last_done;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = res_q.chars[idx_q];
  assign m_axis_tlast  = (idx_q == res_q.last_idx);
  assign beat_done     = busy_q && m_axis_tready;
  assign last_done     = beat_done && m_axis_tlast;
  assign load_o        = in_valid_i && (!busy_q || last_done);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (last_done) begin
      busy_d = 1'b0;
      idx_d  = '0;
    end else if (beat_done) begin
      idx_d  = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      res_q <= result_i;
    end
  end

  `SLE_ASSERT(a_idx_in_range, busy_q |-> (idx_q <= res_q.last_idx), "beat index past last char")
  `SLE_ASSERT(a_load_when_free, load_o |-> (!busy_q || last_done), "result overwritten")
  `SLE_ASSERT(a_stall_holds_idx, (busy_q && !m_axis_tready) |=> (busy_q && $stable(idx_q)),
    "index moved under stall")
  `SLE_ASSERT(a_drain_clears, (last_done && !load_o) |=> !busy_q, "busy after last beat")
  `SLE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !busy_q, "busy during reset")

endmodule
